// ===== hdl/rcir_pkg.sv =====
// ----------------------------------------------------------------------------
// rcir_pkg
// Shared widths, register indexes, command codes and burst timing for the
// car command decoder with IR burst generator.
// ----------------------------------------------------------------------------
package rcir_pkg;

    localparam int DUTY_W = 15;
    localparam int TIME_W = 11;
    localparam int LED_W  = 3;
    localparam int DIR_W  = 4;
    localparam int CHAR_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // turn scaling: inner = (speed * turn * RECIP) >> RECIP_SHIFT == speed * turn / 100
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam int TURN_W      = 7;
    localparam int TURN_C_W    = TURN_W + RECIP_W;
    localparam int PROD_W      = DUTY_W + TURN_C_W;
    localparam logic [RECIP_W-1:0] TURN_RECIP = 23'd5368710;

    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FULL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_3Q    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_HALF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_PCT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_PER   = 3'd4;

    localparam logic [DUTY_W-1:0] RST_DUTY_FULL = 15'd24850;
    localparam logic [DUTY_W-1:0] RST_DUTY_3Q   = 15'd18750;
    localparam logic [DUTY_W-1:0] RST_DUTY_HALF = 15'd12500;
    localparam logic [TURN_W-1:0] RST_TURN_PCT  = 7'd65;
    localparam logic [TIME_W-1:0] RST_POLL_PER  = 11'd1333;

    localparam logic [CHAR_W-1:0] CMD_FWD   = 8'h57;
    localparam logic [CHAR_W-1:0] CMD_LEFT  = 8'h41;
    localparam logic [CHAR_W-1:0] CMD_BACK  = 8'h53;
    localparam logic [CHAR_W-1:0] CMD_RIGHT = 8'h44;
    localparam logic [CHAR_W-1:0] CMD_STOP  = 8'h51;
    localparam logic [CHAR_W-1:0] CMD_IR    = 8'h49;
    localparam logic [CHAR_W-1:0] CMD_SPD1  = 8'h31;
    localparam logic [CHAR_W-1:0] CMD_SPD2  = 8'h32;
    localparam logic [CHAR_W-1:0] CMD_SPD3  = 8'h33;

    localparam logic [DIR_W-1:0] DIR_STOP  = 4'd0;
    localparam logic [DIR_W-1:0] DIR_FWD   = 4'd10;
    localparam logic [DIR_W-1:0] DIR_BACK  = 4'd5;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'd6;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'd9;

    localparam logic [LED_W-1:0] LED_OFF   = 3'd0;
    localparam logic [LED_W-1:0] LED_RED   = 3'd1;
    localparam logic [LED_W-1:0] LED_BLUE  = 3'd2;
    localparam logic [LED_W-1:0] LED_GREEN = 3'd4;

    localparam logic [TIME_W-1:0] FRAME_TICKS = 11'd1680;

    function automatic logic in_window(input logic [TIME_W-1:0] t);
        in_window = (t < 11'd160) ||
                    (t >= 11'd240 && t < 11'd320) ||
                    (t >= 11'd360 && t < 11'd400) ||
                    (t >= 11'd440 && t < 11'd520) ||
                    (t >= 11'd560 && t < 11'd600) ||
                    (t >= 11'd640 && t < 11'd720) ||
                    (t >= 11'd760 && t < 11'd800);
    endfunction

endpackage

// ===== hdl/rc_car_command_ir_burst.sv =====
// ----------------------------------------------------------------------------
// rc_car_command_ir_burst
// Per-tick command decoder for a two-motor car with a two-frame IR burst.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: rx_valid, rx_char, zero pad (16 bits)
//  m_axis    | out       | tdata: rx_taken, ir_level, ir_active, motor_dir,
//            |           |        left_duty, right_duty, led_state (40 bits)
//  cfg       | in        | index 0..4, data 15 bits
//
// One beat per cycle while the output is not stalled: input register, then
// result register. The decode, the poll and burst counters and the single turn
// multiplier sit between them. Synchronous active-low reset; all registers but
// the input and result data return to reset values. A stalled output holds
// its beat; an empty input register takes one more beat before tready drops.
// ----------------------------------------------------------------------------
module rc_car_command_ir_burst
    import rcir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] rx_valid, [8:1] rx_char, [15:9] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] rx_taken, [1] ir_level, [2] ir_active, [6:3] motor_dir,
    // [21:7] left_duty, [36:22] right_duty, [39:37] led_state
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [DUTY_W-1:0]     i_cfg_data
);

    logic [DUTY_W-1:0]     r_duty_full, r_duty_3q, r_duty_half;
    logic [TURN_C_W-1:0]   r_turn_c;
    logic [TIME_W-1:0]     r_poll_per;

    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [TIME_W-1:0]     r_poll_cnt, n_poll_cnt;
    logic [TIME_W-1:0]     r_ir_time, n_ir_time;
    logic                  r_ir_busy, n_ir_busy;
    logic                  r_ir_second, n_ir_second;
    logic                  r_ir_request, n_ir_request;
    logic                  r_ir_bit, n_ir_bit;
    logic [DIR_W-1:0]      r_dir, n_dir;
    logic [DUTY_W-1:0]     r_speed, n_speed;
    logic [DUTY_W-1:0]     r_left, n_left;
    logic [DUTY_W-1:0]     r_right, n_right;
    logic [LED_W-1:0]      r_led_now, n_led_now;
    logic [LED_W-1:0]      r_led_saved, n_led_saved;

    logic                  w_advance;
    logic                  w_rx_valid;
    logic [CHAR_W-1:0]     w_rx_char;
    logic                  w_taken;
    logic                  w_ir_restart;
    logic [PROD_W-1:0]     w_prod;
    logic [DUTY_W:0]       w_inner_raw;
    logic [DUTY_W-1:0]     w_inner;
    logic [TIME_W:0]       w_poll_inc;
    logic [OUT_DATA_W-1:0] n_out_data;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    assign w_rx_valid = r_in_data[0];
    assign w_rx_char  = r_in_data[CHAR_W:1];

    assign w_prod      = PROD_W'(r_speed) * PROD_W'(r_turn_c);
    assign w_inner_raw = w_prod[RECIP_SHIFT +: DUTY_W+1];
    assign w_inner     = w_inner_raw[DUTY_W] ? {DUTY_W{1'b1}} : w_inner_raw[DUTY_W-1:0];

    assign w_poll_inc  = {1'b0, r_poll_cnt} + 1'b1;

    always_comb begin
        n_poll_cnt   = r_poll_cnt;
        n_ir_busy    = r_ir_busy;
        n_ir_second  = r_ir_second;
        n_ir_request = r_ir_request;
        n_ir_bit     = r_ir_bit;
        n_dir        = r_dir;
        n_speed      = r_speed;
        n_left       = r_left;
        n_right      = r_right;
        n_led_now    = r_led_now;
        n_led_saved  = r_led_saved;
        w_taken      = 1'b0;
        w_ir_restart = 1'b0;

        if (r_ir_busy) begin
            priority if (in_window(r_ir_time)) begin
                n_ir_bit = !r_ir_bit;
            end else if (r_ir_time >= FRAME_TICKS) begin
                w_ir_restart = 1'b1;
                if (!r_ir_second) begin
                    n_ir_second = 1'b1;
                end else begin
                    n_ir_busy   = 1'b0;
                    n_ir_second = 1'b0;
                end
            end else begin
                n_ir_bit = 1'b0;
            end
        end else begin
            if (r_poll_cnt == '0) begin
                if (w_rx_valid) begin
                    w_taken = 1'b1;
                    unique case (w_rx_char)
                        CMD_FWD: begin
                            n_led_now = r_led_saved;
                            n_dir     = DIR_FWD;
                            n_left    = r_speed;
                            n_right   = r_speed;
                        end
                        CMD_LEFT: begin
                            n_led_now = r_led_saved;
                            n_dir     = DIR_LEFT;
                            n_left    = w_inner;
                            n_right   = r_speed;
                        end
                        CMD_BACK: begin
                            n_led_now = r_led_saved;
                            n_dir     = DIR_BACK;
                            n_left    = r_speed;
                            n_right   = r_speed;
                        end
                        CMD_RIGHT: begin
                            n_led_now = r_led_saved;
                            n_dir     = DIR_RIGHT;
                            n_left    = r_speed;
                            n_right   = w_inner;
                        end
                        CMD_STOP: begin
                            if (r_led_now != LED_OFF) begin
                                n_led_saved = r_led_now;
                            end
                            n_led_now = LED_OFF;
                            n_dir     = DIR_STOP;
                        end
                        CMD_IR: begin
                            n_ir_request = 1'b1;
                        end
                        CMD_SPD1: begin
                            n_led_now   = LED_BLUE;
                            n_led_saved = LED_BLUE;
                            n_speed     = r_duty_full;
                        end
                        CMD_SPD2: begin
                            n_led_now   = LED_GREEN;
                            n_led_saved = LED_GREEN;
                            n_speed     = r_duty_3q;
                        end
                        CMD_SPD3: begin
                            n_led_now   = LED_RED;
                            n_led_saved = LED_RED;
                            n_speed     = r_duty_half;
                        end
                        default: begin
                        end
                    endcase
                end
                if (r_ir_request) begin
                    n_ir_request = 1'b0;
                    n_ir_busy    = 1'b1;
                    w_ir_restart = 1'b1;
                end
            end
            n_poll_cnt = (w_poll_inc >= {1'b0, r_poll_per}) ? '0 : w_poll_inc[TIME_W-1:0];
        end

        n_ir_time  = (w_ir_restart ? '0 : r_ir_time) + 1'b1;
        n_out_data = {n_led_now, n_right, n_left, n_dir, n_ir_busy, n_ir_bit, w_taken};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_full <= RST_DUTY_FULL;
            r_duty_3q   <= RST_DUTY_3Q;
            r_duty_half <= RST_DUTY_HALF;
            r_turn_c    <= TURN_C_W'(RST_TURN_PCT) * TURN_C_W'(TURN_RECIP);
            r_poll_per  <= RST_POLL_PER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DUTY_FULL: r_duty_full <= i_cfg_data;
                CFG_DUTY_3Q:   r_duty_3q   <= i_cfg_data;
                CFG_DUTY_HALF: r_duty_half <= i_cfg_data;
                CFG_TURN_PCT:  r_turn_c    <= TURN_C_W'(i_cfg_data[TURN_W-1:0]) *
                                              TURN_C_W'(TURN_RECIP);
                CFG_POLL_PER:  r_poll_per  <= i_cfg_data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_cnt   <= '0;
            r_ir_time    <= '0;
            r_ir_busy    <= 1'b0;
            r_ir_second  <= 1'b0;
            r_ir_request <= 1'b0;
            r_ir_bit     <= 1'b0;
            r_dir        <= DIR_STOP;
            r_speed      <= RST_DUTY_HALF;
            r_left       <= RST_DUTY_HALF;
            r_right      <= RST_DUTY_HALF;
            r_led_now    <= LED_OFF;
            r_led_saved  <= LED_RED;
        end else if (w_advance) begin
            r_poll_cnt   <= n_poll_cnt;
            r_ir_time    <= n_ir_time;
            r_ir_busy    <= n_ir_busy;
            r_ir_second  <= n_ir_second;
            r_ir_request <= n_ir_request;
            r_ir_bit     <= n_ir_bit;
            r_dir        <= n_dir;
            r_speed      <= n_speed;
            r_left       <= n_left;
            r_right      <= n_right;
            r_led_now    <= n_led_now;
            r_led_saved  <= n_led_saved;
        end
    end

    a_second_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ir_busy |-> !r_ir_second)
        else $error("second frame flag set outside a burst");

    a_burst_ends_after_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ir_busy) |-> $past(r_ir_second))
        else $error("burst ended before its second frame");

    a_burst_start_consumes_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ir_busy) |-> $past(r_ir_request) && !r_ir_request)
        else $error("burst started without a queued request");

    a_saved_led_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led_saved != LED_OFF)
        else $error("saved LED state is dark");

endmodule
